FILE: hw/rtl/rhe_pkg.sv
// rhe_pkg: shared types, constants and helper functions of the RGB
// histogram equalizer. Used by rgb_histogram_equalizer and its testbench.
// No dependencies.
package rhe_pkg;

    // Geometry
    localparam int CH         = 3;
    localparam int BINS       = 256;
    localparam int MAX_PIXELS = 65536;
    localparam int CODE_W     = 8;
    localparam int BIN_W      = $clog2(BINS);
    localparam int CH_W       = $clog2(CH);
    localparam int ADDR_W     = $clog2(CH * BINS);
    localparam int CNT_W      = 17;            // pixel count and bin count
    localparam int Q_W        = 16;            // Q0.16 table entry
    localparam int STEP_W     = $clog2(Q_W);
    localparam int NUM_W      = CNT_W + Q_W;   // cum * 65535

    // Item function codes
    typedef enum logic [1:0] {
        FN_CLEAR = 2'd0,
        FN_COUNT = 2'd1,
        FN_MAP   = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        ST_CLR    = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_CNT_RD = 10'b00_0000_0100,
        ST_CNT_WR = 10'b00_0000_1000,
        ST_BLD_RD = 10'b00_0001_0000,
        ST_BLD_AD = 10'b00_0010_0000,
        ST_BLD_DV = 10'b00_0100_0000,
        ST_MAP_RD = 10'b00_1000_0000,
        ST_MAP_WT = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } t_state;

    // floor(code*(BINS-1)/255) via reciprocal: (x + (x>>8) + 1) >> 8
    function automatic logic [BIN_W-1:0] bin_of(input logic [CODE_W-1:0] code);
        logic [CNT_W-1:0] x;
        logic [CNT_W-1:0] s;
        logic [CNT_W-1:0] b;
        x = CNT_W'(code) * CNT_W'(BINS - 1);
        s = x + (x >> 8) + CNT_W'(1);
        b = s >> 8;
        if (b > CNT_W'(BINS - 1)) begin
            b = CNT_W'(BINS - 1);
        end
        return b[BIN_W-1:0];
    endfunction

    // Flat memory address of a channel's bin
    function automatic logic [ADDR_W-1:0] addr_of(input logic [CH_W-1:0] ch,
                                                  input logic [BIN_W-1:0] bin);
        return ADDR_W'(ch) * ADDR_W'(BINS) + ADDR_W'(bin);
    endfunction

endpackage

FILE: hw/rtl/rgb_histogram_equalizer.sv
// rgb_histogram_equalizer: per-channel histogram equalization, top level.
// Depends on rhe_pkg and rhe_ram.
//
//   beat   | valid    | stall    | payload
//   -------+----------+----------+----------------------------------------------
//   input  | i_valid  | o_stall  | i_func, i_red, i_green, i_blue
//   output | o_valid  | i_stall  | o_eq_red/green/blue, o_pixels_counted,
//          |          |          | o_count_overflow
//
// One item at a time. Count: a read and a write of bin memory per channel.
// Map with table current: a table memory read per channel. The first map
// after a change adds a table build of 768 entries, each one bin read, one
// add and a 16-step restoring divider. Clear: a sweep writing zero to every
// bin. Reset runs the same sweep with o_stall high. A result waits in the
// output register under i_stall; the next item is taken meanwhile.
module rgb_histogram_equalizer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_func,
    input  logic [7:0]                i_red,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_blue,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [15:0]               o_eq_red,
    output logic [15:0]               o_eq_green,
    output logic [15:0]               o_eq_blue,
    output logic [16:0]               o_pixels_counted,
    output logic                      o_count_overflow
);

    rhe_pkg::t_state r_state;

    // Control
    logic                         r_clr_item;
    logic                         r_ready;
    logic [rhe_pkg::CNT_W-1:0]    r_total;
    logic [rhe_pkg::CH_W-1:0]     r_ch;
    logic [rhe_pkg::BIN_W-1:0]    r_b;
    logic [rhe_pkg::STEP_W-1:0]   r_step;
    logic                         r_o_valid;

    // Payload
    logic [rhe_pkg::BIN_W-1:0]    r_bin [rhe_pkg::CH];
    logic [rhe_pkg::Q_W-1:0]      r_eq  [rhe_pkg::CH];
    logic                         r_ovf;
    logic [rhe_pkg::CNT_W-1:0]    r_cum;
    logic [rhe_pkg::CNT_W-1:0]    r_rem;
    logic [rhe_pkg::Q_W-1:0]      r_lo;
    logic [rhe_pkg::Q_W-1:0]      r_quo;
    logic [rhe_pkg::Q_W-1:0]      r_o_eq [rhe_pkg::CH];
    logic [rhe_pkg::CNT_W-1:0]    r_o_cnt;
    logic                         r_o_ovf;

    // Memory ports
    logic                         cnt_wr_en, cnt_rd_en, tbl_wr_en, tbl_rd_en;
    logic [rhe_pkg::ADDR_W-1:0]   cnt_wr_addr, cnt_rd_addr, tbl_addr;
    logic [rhe_pkg::CNT_W-1:0]    cnt_wr_data, cnt_rd_data;
    logic [rhe_pkg::Q_W-1:0]      tbl_rd_data;

    // Datapath
    logic                         accept, out_free, last_b, last_ch;
    logic [rhe_pkg::ADDR_W-1:0]   a_item, a_sweep;
    logic [rhe_pkg::CNT_W-1:0]    n_cum;
    logic [rhe_pkg::NUM_W-1:0]    n_num;
    logic [rhe_pkg::CNT_W:0]      dv_t;
    logic                         dv_ge;
    logic [rhe_pkg::CNT_W-1:0]    n_rem;
    logic [rhe_pkg::Q_W-1:0]      n_quo;

    assign o_stall  = (r_state != rhe_pkg::ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign last_b   = (r_b == rhe_pkg::BIN_W'(rhe_pkg::BINS - 1));
    assign last_ch  = (r_ch == rhe_pkg::CH_W'(rhe_pkg::CH - 1));
    assign a_item   = rhe_pkg::addr_of(r_ch, r_bin[r_ch]);
    assign a_sweep  = rhe_pkg::addr_of(r_ch, r_b);

    // Running sum restarts at bin 0 of each channel; numerator = cum*65535
    assign n_cum = ((r_b == '0) ? '0 : r_cum) + cnt_rd_data;
    assign n_num = {n_cum, {rhe_pkg::Q_W{1'b0}}} - rhe_pkg::NUM_W'(n_cum);

    // One restoring divide step
    assign dv_t  = {r_rem, r_lo[rhe_pkg::Q_W-1]};
    assign dv_ge = (dv_t >= {1'b0, r_total});
    assign n_rem = dv_ge ? rhe_pkg::CNT_W'(dv_t - {1'b0, r_total})
                         : rhe_pkg::CNT_W'(dv_t);
    assign n_quo = {r_quo[rhe_pkg::Q_W-2:0], dv_ge};

    // Bin count memory: clear sweep, increment, build reads
    always_comb begin
        cnt_wr_en   = (r_state == rhe_pkg::ST_CLR) || (r_state == rhe_pkg::ST_CNT_WR);
        cnt_wr_addr = (r_state == rhe_pkg::ST_CLR) ? a_sweep : a_item;
        cnt_wr_data = (r_state == rhe_pkg::ST_CLR) ? '0
                                                   : cnt_rd_data + rhe_pkg::CNT_W'(1);
        cnt_rd_en   = (r_state == rhe_pkg::ST_CNT_RD) || (r_state == rhe_pkg::ST_BLD_RD);
        cnt_rd_addr = (r_state == rhe_pkg::ST_BLD_RD) ? a_sweep : a_item;
    end

    // Table memory: written at the end of each divide, read by map
    always_comb begin
        tbl_wr_en = (r_state == rhe_pkg::ST_BLD_DV)
                 && (r_step == rhe_pkg::STEP_W'(rhe_pkg::Q_W - 1));
        tbl_rd_en = (r_state == rhe_pkg::ST_MAP_RD);
        tbl_addr  = (r_state == rhe_pkg::ST_MAP_RD) ? a_item : a_sweep;
    end

    rhe_ram #(.W(rhe_pkg::CNT_W), .DEPTH(rhe_pkg::CH * rhe_pkg::BINS)) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_wr_en),
        .i_wr_addr (cnt_wr_addr),
        .i_wr_data (cnt_wr_data),
        .i_rd_en   (cnt_rd_en),
        .i_rd_addr (cnt_rd_addr),
        .o_rd_data (cnt_rd_data)
    );

    rhe_ram #(.W(rhe_pkg::Q_W), .DEPTH(rhe_pkg::CH * rhe_pkg::BINS)) u_tbl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_addr),
        .i_wr_data (n_quo),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (tbl_addr),
        .o_rd_data (tbl_rd_data)
    );

    // Sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rhe_pkg::ST_CLR;
            r_clr_item <= 1'b0;
            r_ready    <= 1'b0;
            r_total    <= '0;
            r_ch       <= '0;
            r_b        <= '0;
            r_step     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            // Output beat: loaded on completion, dropped once taken
            if ((r_state == rhe_pkg::ST_DONE) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                rhe_pkg::ST_CLR: begin
                    if (last_b) begin
                        r_b <= '0;
                        if (last_ch) begin
                            r_ch    <= '0;
                            r_state <= r_clr_item ? rhe_pkg::ST_DONE : rhe_pkg::ST_IDLE;
                        end else begin
                            r_ch <= r_ch + rhe_pkg::CH_W'(1);
                        end
                    end else begin
                        r_b <= r_b + rhe_pkg::BIN_W'(1);
                    end
                end
                rhe_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_ch <= '0;
                        r_b  <= '0;
                        unique case (rhe_pkg::t_func'(i_func))
                            rhe_pkg::FN_CLEAR: begin
                                r_total    <= '0;
                                r_ready    <= 1'b0;
                                r_clr_item <= 1'b1;
                                r_state    <= rhe_pkg::ST_CLR;
                            end
                            rhe_pkg::FN_COUNT: begin
                                if (r_total >= rhe_pkg::CNT_W'(rhe_pkg::MAX_PIXELS)) begin
                                    r_state <= rhe_pkg::ST_DONE;
                                end else begin
                                    r_total <= r_total + rhe_pkg::CNT_W'(1);
                                    r_ready <= 1'b0;
                                    r_state <= rhe_pkg::ST_CNT_RD;
                                end
                            end
                            rhe_pkg::FN_MAP: begin
                                priority if (r_total == '0) begin
                                    r_state <= rhe_pkg::ST_DONE;
                                end else if (!r_ready) begin
                                    r_state <= rhe_pkg::ST_BLD_RD;
                                end else begin
                                    r_state <= rhe_pkg::ST_MAP_RD;
                                end
                            end
                            default: begin
                                r_state <= rhe_pkg::ST_DONE;
                            end
                        endcase
                    end
                end
                rhe_pkg::ST_CNT_RD: begin
                    r_state <= rhe_pkg::ST_CNT_WR;
                end
                rhe_pkg::ST_CNT_WR: begin
                    if (last_ch) begin
                        r_state <= rhe_pkg::ST_DONE;
                    end else begin
                        r_ch    <= r_ch + rhe_pkg::CH_W'(1);
                        r_state <= rhe_pkg::ST_CNT_RD;
                    end
                end
                rhe_pkg::ST_BLD_RD: begin
                    r_state <= rhe_pkg::ST_BLD_AD;
                end
                rhe_pkg::ST_BLD_AD: begin
                    r_step  <= '0;
                    r_state <= rhe_pkg::ST_BLD_DV;
                end
                rhe_pkg::ST_BLD_DV: begin
                    r_step <= r_step + rhe_pkg::STEP_W'(1);
                    if (r_step == rhe_pkg::STEP_W'(rhe_pkg::Q_W - 1)) begin
                        if (last_b) begin
                            r_b <= '0;
                            if (last_ch) begin
                                r_ch    <= '0;
                                r_ready <= 1'b1;
                                r_state <= rhe_pkg::ST_MAP_RD;
                            end else begin
                                r_ch    <= r_ch + rhe_pkg::CH_W'(1);
                                r_state <= rhe_pkg::ST_BLD_RD;
                            end
                        end else begin
                            r_b     <= r_b + rhe_pkg::BIN_W'(1);
                            r_state <= rhe_pkg::ST_BLD_RD;
                        end
                    end
                end
                rhe_pkg::ST_MAP_RD: begin
                    r_state <= rhe_pkg::ST_MAP_WT;
                end
                rhe_pkg::ST_MAP_WT: begin
                    if (last_ch) begin
                        r_state <= rhe_pkg::ST_DONE;
                    end else begin
                        r_ch    <= r_ch + rhe_pkg::CH_W'(1);
                        r_state <= rhe_pkg::ST_MAP_RD;
                    end
                end
                rhe_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_clr_item <= 1'b0;
                        r_state    <= rhe_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= rhe_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Item payload, divider and result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin[0] <= rhe_pkg::bin_of(i_red);
            r_bin[1] <= rhe_pkg::bin_of(i_green);
            r_bin[2] <= rhe_pkg::bin_of(i_blue);
            for (int c = 0; c < rhe_pkg::CH; c++) begin
                r_eq[c] <= '0;
            end
            r_ovf <= (rhe_pkg::t_func'(i_func) == rhe_pkg::FN_COUNT)
                  && (r_total >= rhe_pkg::CNT_W'(rhe_pkg::MAX_PIXELS));
        end
        if (r_state == rhe_pkg::ST_BLD_AD) begin
            r_cum <= n_cum;
            r_rem <= n_num[rhe_pkg::NUM_W-1:rhe_pkg::Q_W];
            r_lo  <= n_num[rhe_pkg::Q_W-1:0];
        end
        if (r_state == rhe_pkg::ST_BLD_DV) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[rhe_pkg::Q_W-2:0], 1'b0};
            r_quo <= n_quo;
        end
        if (r_state == rhe_pkg::ST_MAP_WT) begin
            r_eq[r_ch] <= tbl_rd_data;
        end
        if ((r_state == rhe_pkg::ST_DONE) && out_free) begin
            for (int c = 0; c < rhe_pkg::CH; c++) begin
                r_o_eq[c] <= r_eq[c];
            end
            r_o_cnt <= r_total;
            r_o_ovf <= r_ovf;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_eq_red         = r_o_eq[0];
    assign o_eq_green       = r_o_eq[1];
    assign o_eq_blue        = r_o_eq[2];
    assign o_pixels_counted = r_o_cnt;
    assign o_count_overflow = r_o_ovf;

endmodule

FILE: hw/rtl/rhe_ram.sv
// rhe_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module rhe_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [W-1:0]             i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [W-1:0]             o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: tb/rgb_histogram_equalizer_tb.sv
// rgb_histogram_equalizer_tb: self-checking bench for the per-channel histogram equalizer.
// Drives clear/count/map/nop beats; checks predicted or typed results field by field.
// Depends on rhe_pkg and the rgb_histogram_equalizer RTL.
module rgb_histogram_equalizer_tb;

    typedef struct packed {
        logic [15:0] eq_r;
        logic [15:0] eq_g;
        logic [15:0] eq_b;
        logic [16:0] pix;
        logic        ovf;
    } t_eq_result;

    typedef struct {
        rhe_pkg::t_func fn;
        logic [7:0]     r, g, b;
        bit             typed;
        t_eq_result     res;
    } t_stim_row;

    logic        i_clk, i_rst_n, i_valid, o_stall, i_stall, o_valid;
    logic [1:0]  i_func;
    logic [7:0]  i_red, i_green, i_blue;
    logic [15:0] o_eq_red, o_eq_green, o_eq_blue;
    logic [16:0] o_pixels_counted;
    logic        o_count_overflow;

    // typed expectation that travels with the beat
    bit         row_typed;
    t_eq_result row_res;

    // predictor state
    logic [16:0] hist [3][256];
    logic [15:0] cdf_tab [3][256];
    logic [16:0] pix_total;
    bit          cdf_ready;

    t_eq_result  pending_q[$];
    bit          failed;
    bit          hold_req;     // receiver long hold-off request

    rgb_histogram_equalizer u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #16_000_000;
        $display("rgb_histogram_equalizer: mismatch");
        $finish;
    end

    // rebuild the normalized cumulative tables
    task automatic build_cdf();
        logic [16:0] cum;
        logic [32:0] num;
        for (int c = 0; c < 3; c++) begin
            cum = '0;
            for (int k = 0; k < 256; k++) begin
                cum = cum + hist[c][k];
                num = 33'(cum) * 33'd65535;
                cdf_tab[c][k] = 16'(num / 33'(pix_total));
            end
        end
        cdf_ready = 1'b1;
    endtask

    // apply one accepted beat to the predictor, return its result
    task automatic equalize_pixel(input rhe_pkg::t_func fn, input logic [7:0] r, g, b,
                                  output t_eq_result res);
        res = '0;
        case (fn)
            rhe_pkg::FN_CLEAR: begin
                foreach (hist[c, k]) hist[c][k] = '0;
                pix_total = '0;
                cdf_ready = 1'b0;
            end
            rhe_pkg::FN_COUNT: begin
                if (pix_total >= 17'(rhe_pkg::MAX_PIXELS)) begin
                    res.ovf = 1'b1;
                end else begin
                    hist[0][r]++;
                    hist[1][g]++;
                    hist[2][b]++;
                    pix_total++;
                    cdf_ready = 1'b0;
                end
            end
            rhe_pkg::FN_MAP: begin
                if (pix_total != 0) begin
                    if (!cdf_ready) build_cdf();
                    res.eq_r = cdf_tab[0][r];
                    res.eq_g = cdf_tab[1][g];
                    res.eq_b = cdf_tab[2][b];
                end
            end
            default: ;
        endcase
        res.pix = pix_total;
    endtask

    // input monitor: predict on each accepted beat
    always @(posedge i_clk) begin
        t_eq_result res;
        if (i_rst_n && i_valid && !o_stall) begin
            equalize_pixel(rhe_pkg::t_func'(i_func), i_red, i_green, i_blue, res);
            pending_q = {pending_q, (row_typed ? row_res : res)};
        end
    end

    // output monitor: compare against the oldest expectation
    always @(posedge i_clk) begin
        t_eq_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result pix=%0d", $realtime, o_pixels_counted);
                failed = 1'b1;
            end else begin
                want = pending_q.pop_front();
                if (want.eq_r !== o_eq_red)
                    $display("%0t: eq_red exp %0d got %0d", $realtime, want.eq_r, o_eq_red);
                if (want.eq_g !== o_eq_green)
                    $display("%0t: eq_green exp %0d got %0d", $realtime, want.eq_g,
                             o_eq_green);
                if (want.eq_b !== o_eq_blue)
                    $display("%0t: eq_blue exp %0d got %0d", $realtime, want.eq_b, o_eq_blue);
                if (want.pix !== o_pixels_counted)
                    $display("%0t: pixels_counted exp %0d got %0d", $realtime, want.pix,
                             o_pixels_counted);
                if (want.ovf !== o_count_overflow)
                    $display("%0t: count_overflow exp %0d got %0d", $realtime, want.ovf,
                             o_count_overflow);
                if (want !== {o_eq_red, o_eq_green, o_eq_blue, o_pixels_counted,
                              o_count_overflow})
                    failed = 1'b1;
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end
            if ($urandom_range(0, 99) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
            end
        end
    end

    // offer one beat and wait for it to be taken
    task automatic send_pixel(input rhe_pkg::t_func fn, input logic [7:0] r, g, b,
                              input bit typed = 1'b0, input t_eq_result res = '0);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= fn;
        i_red     <= r;
        i_green   <= g;
        i_blue    <= b;
        row_typed <= typed;
        row_res   <= res;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random(input rhe_pkg::t_func fn);
        send_pixel(fn, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    t_stim_row rows[$];
    int        n_items;

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_func    <= rhe_pkg::FN_NOP;
        i_red     <= '0;
        i_green   <= '0;
        i_blue    <= '0;
        row_typed <= 1'b0;
        row_res   <= '0;
        failed    = 1'b0;
        hold_req  = 1'b0;
        foreach (hist[c, k]) hist[c][k] = '0;
        pix_total = '0;
        cdf_ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: typed results where they are obvious
        rows = '{
            '{rhe_pkg::FN_MAP,   8'h00, 8'h00, 8'h00, 1, '{0, 0, 0, 0, 0}},
            '{rhe_pkg::FN_NOP,   8'hFF, 8'hFF, 8'hFF, 1, '{0, 0, 0, 0, 0}},
            '{rhe_pkg::FN_COUNT, 8'hFF, 8'h00, 8'h80, 1, '{0, 0, 0, 1, 0}},
            '{rhe_pkg::FN_MAP,   8'hFF, 8'h00, 8'h80, 1, '{65535, 65535, 65535, 1, 0}},
            '{rhe_pkg::FN_MAP,   8'h00, 8'hFF, 8'h7F, 1, '{0, 65535, 0, 1, 0}},
            '{rhe_pkg::FN_COUNT, 8'h00, 8'hFF, 8'h00, 1, '{0, 0, 0, 2, 0}},
            '{rhe_pkg::FN_MAP,   8'h00, 8'h00, 8'h00, 0, '0},
            '{rhe_pkg::FN_MAP,   8'hFF, 8'hFF, 8'hFF, 0, '0},
            '{rhe_pkg::FN_NOP,   8'h55, 8'hAA, 8'h55, 1, '{0, 0, 0, 2, 0}},
            '{rhe_pkg::FN_CLEAR, 8'hAA, 8'h55, 8'hAA, 1, '{0, 0, 0, 0, 0}},
            '{rhe_pkg::FN_MAP,   8'h55, 8'hAA, 8'hFF, 1, '{0, 0, 0, 0, 0}},
            '{rhe_pkg::FN_COUNT, 8'h01, 8'h02, 8'h04, 0, '0},
            '{rhe_pkg::FN_COUNT, 8'h08, 8'h10, 8'h20, 0, '0},
            '{rhe_pkg::FN_COUNT, 8'h40, 8'h80, 8'hFF, 0, '0},
            '{rhe_pkg::FN_COUNT, 8'hAA, 8'h55, 8'hFE, 0, '0},
            '{rhe_pkg::FN_MAP,   8'h40, 8'h10, 8'h04, 0, '0},
            '{rhe_pkg::FN_MAP,   8'h00, 8'hFF, 8'h80, 0, '0},
            '{rhe_pkg::FN_COUNT, 8'h40, 8'h40, 8'h40, 0, '0},
            '{rhe_pkg::FN_MAP,   8'hAA, 8'h55, 8'hFE, 0, '0},
            '{rhe_pkg::FN_NOP,   8'h00, 8'h00, 8'h00, 0, '0}
        };
        foreach (rows[i])
            send_pixel(rows[i].fn, rows[i].r, rows[i].g, rows[i].b, rows[i].typed,
                       rows[i].res);

        // random part: mostly clear/count/map frames, some noise
        n_items  = 0;
        hold_req = 1'b1;
        while (n_items < 830) begin
            if ($urandom_range(0, 99) < 85) begin
                int n_cnt, n_map;
                n_cnt = $urandom_range(1, 30);
                n_map = $urandom_range(10, 40);
                if ($urandom_range(0, 3) != 0) send_random(rhe_pkg::FN_CLEAR);
                repeat (n_cnt) send_random(rhe_pkg::FN_COUNT);
                repeat (n_map) send_random(rhe_pkg::FN_MAP);
                n_items += n_cnt + n_map + 1;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_random(rhe_pkg::t_func'($urandom_range(0, 3)));
                    n_items++;
                end
            end
        end
        i_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!failed)
            $display("rgb_histogram_equalizer: match");
        else
            $display("rgb_histogram_equalizer: mismatch");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/rhe_pkg.sv
hw/rtl/rhe_ram.sv
hw/rtl/rgb_histogram_equalizer.sv
tb/rgb_histogram_equalizer_tb.sv
